// ===== hw/rtl/lphm_pkg.sv =====
// shared types, codes and constants of the linear probe hash map
package lphm_pkg;

    localparam int TableSlotsDef = 1024;
    localparam int CfgW          = 11;
    localparam logic [CfgW-1:0] CfgReset = 11'd1024;
    localparam int PosMaxW       = 16;
    localparam int DivBits       = 4;
    localparam logic [31:0] MixC1 = 32'h85ebca6b;
    localparam logic [31:0] MixC2 = 32'hc2b2ae35;

    localparam logic [2:0] REQ_SET   = 3'd0;
    localparam logic [2:0] REQ_ERASE = 3'd1;
    localparam logic [2:0] REQ_GET   = 3'd2;
    localparam logic [2:0] REQ_RAW   = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_KEY_ZERO,
        ST_RANGE
    } status_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic               key_zero;
        logic [31:0]        key;
        logic [31:0]        value;
        logic [9:0]         slot_index;
        logic [PosMaxW-1:0] home;
    } job_t;

endpackage

// ===== hw/rtl/lphm_front.sv =====
// request intake: murmur3 finalizer and iterative modulo to the home slot
module lphm_front
    import lphm_pkg::*;
#(
    parameter int CW = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hold,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    req_type,
    input  logic [31:0]   key,
    input  logic [31:0]   value,
    input  logic [9:0]    slot_index,
    input  logic [CW-1:0] n,
    output logic          q_valid,
    input  logic          q_ready,
    output job_t          q_data
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL1,
        F_MUL2,
        F_FOLD,
        F_DIV,
        F_PUSH
    } fstate_t;

    localparam int DivSteps = 32 / DivBits;
    localparam int CntW = $clog2(DivSteps);

    fstate_t         state_reg;
    job_t            job_reg;
    logic [31:0]     h_reg;
    logic [31:0]     dvd_reg;
    logic [31:0]     dvd_next;
    logic [CW-1:0]   rem_reg;
    logic [CW-1:0]   rem_next;
    logic [CntW-1:0] cnt_reg;
    logic [31:0]     x1;
    logic [31:0]     x2;

    assign in_ready = (state_reg == F_IDLE) && !hold;
    assign q_valid  = (state_reg == F_PUSH);
    assign q_data   = job_reg;
    assign x1       = job_reg.key ^ (job_reg.key >> 16);
    assign x2       = h_reg ^ (h_reg >> 13);

    // restoring remainder, DivBits dividend bits per cycle
    always_comb
    begin
        logic [CW:0]   t;
        logic [CW-1:0] r;
        logic [31:0]   d;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < DivBits; i++)
        begin
            t = {r, d[31]};
            d = {d[30:0], 1'b0};
            if (t >= {1'b0, n})
            begin
                t = t - {1'b0, n};
            end
            r = t[CW-1:0];
        end
        rem_next = r;
        dvd_next = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            job_reg   <= '0;
            h_reg     <= '0;
            dvd_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        job_reg.req_type   <= req_type;
                        job_reg.key        <= key;
                        job_reg.value      <= value;
                        job_reg.slot_index <= slot_index;
                        job_reg.key_zero   <= (key == 32'd0);
                        job_reg.home       <= '0;
                        if (req_type inside {REQ_SET, REQ_ERASE, REQ_GET} && key != 32'd0)
                        begin
                            state_reg <= F_MUL1;
                        end
                        else
                        begin
                            state_reg <= F_PUSH;
                        end
                    end
                end
                F_MUL1:
                begin
                    h_reg     <= x1 * MixC1;
                    state_reg <= F_MUL2;
                end
                F_MUL2:
                begin
                    h_reg     <= x2 * MixC2;
                    state_reg <= F_FOLD;
                end
                F_FOLD:
                begin
                    dvd_reg   <= h_reg ^ (h_reg >> 16);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= F_DIV;
                end
                F_DIV:
                begin
                    dvd_reg <= dvd_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CntW'(DivSteps - 1))
                    begin
                        job_reg.home <= PosMaxW'(rem_next);
                        state_reg    <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (q_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lphm_queue.sv =====
// two-entry job queue between intake and probe engine
module lphm_queue
    import lphm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/lphm_back.sv =====
// probe engine: key and value memories, probing, clear sweep, result register
module lphm_back
    import lphm_pkg::*;
#(
    parameter int TABLE_SLOTS = TableSlotsDef,
    parameter int IW = 10,
    parameter int CW = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [CW-1:0] n,
    input  logic          q_valid,
    output logic          q_ready,
    input  job_t          q_data,
    output logic          init,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   result_value,
    output status_t       status,
    output logic          found,
    output logic [10:0]   live_count
);

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_READ,
        B_CHECK,
        B_CLEAR
    } bstate_t;

    bstate_t       state_reg, state_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [CW-1:0] step_reg, step_next;
    job_t          job_reg, job_next;
    logic [CW-1:0] live_reg, live_next;
    logic          ov_reg, ov_next;
    logic [31:0]   rv_reg, rv_next;
    status_t       st_reg, st_next;
    logic          fd_reg, fd_next;
    logic [10:0]   lc_reg, lc_next;

    logic [31:0] key_mem [TABLE_SLOTS];
    logic [31:0] val_mem [TABLE_SLOTS];
    logic [31:0] key_rd;
    logic [31:0] val_rd;
    logic        key_we;
    logic        val_we;
    logic [31:0] wr_key;
    logic [31:0] wr_val;

    logic          out_free;
    logic          cur_eq;
    logic          cur_zero;
    logic          val_nz;
    logic          last_step;
    logic          last_idx;
    logic [IW-1:0] pos_wrap;

    assign init         = (state_reg == B_INIT);
    assign out_valid    = ov_reg;
    assign result_value = rv_reg;
    assign status       = st_reg;
    assign found        = fd_reg;
    assign live_count   = lc_reg;

    assign out_free  = !ov_reg || out_ready;
    assign cur_eq    = (key_rd == job_reg.key);
    assign cur_zero  = (key_rd == 32'd0);
    assign val_nz    = (val_rd != 32'd0);
    assign last_step = (32'(step_reg) + 32'd1 == 32'(n));
    assign last_idx  = (32'(pos_reg) == 32'(TABLE_SLOTS - 1));
    assign pos_wrap  = (32'(pos_reg) + 32'd1 == 32'(n)) ? '0 : pos_reg + 1'b1;

    // memories read at the probe position, data registered
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[pos_reg] <= wr_key;
        end
        if (val_we)
        begin
            val_mem[pos_reg] <= wr_val;
        end
        key_rd <= key_mem[pos_reg];
        val_rd <= val_mem[pos_reg];
    end

    always_comb
    begin
        logic          done;
        logic [31:0]   rv;
        status_t       st;
        logic          fd;
        logic          kw;
        logic          vw;
        logic [31:0]   vwd;
        logic          ldec;
        logic          linc;
        logic [CW-1:0] lv;

        state_next = state_reg;
        pos_next   = pos_reg;
        step_next  = step_reg;
        job_next   = job_reg;
        live_next  = live_reg;
        ov_next    = (ov_reg && out_ready) ? 1'b0 : ov_reg;
        rv_next    = rv_reg;
        st_next    = st_reg;
        fd_next    = fd_reg;
        lc_next    = lc_reg;
        key_we     = 1'b0;
        val_we     = 1'b0;
        wr_key     = job_reg.key;
        wr_val     = job_reg.value;
        q_ready    = 1'b0;

        done = 1'b0;
        rv   = 32'd0;
        st   = ST_OK;
        fd   = 1'b0;
        kw   = 1'b0;
        vw   = 1'b0;
        vwd  = job_reg.value;
        ldec = 1'b0;
        linc = 1'b0;

        // outcome of the current probe
        if (job_reg.key_zero && job_reg.req_type inside {REQ_SET, REQ_ERASE, REQ_GET})
        begin
            done = 1'b1;
            st   = ST_KEY_ZERO;
        end
        else
        begin
            case (job_reg.req_type)
                REQ_SET:
                begin
                    if (cur_eq || cur_zero)
                    begin
                        done = 1'b1;
                        kw   = 1'b1;
                        vw   = 1'b1;
                        ldec = !cur_zero && val_nz;
                        linc = (job_reg.value != 32'd0);
                    end
                    else if (last_step)
                    begin
                        done = 1'b1;
                        st   = ST_FULL;
                    end
                end
                REQ_ERASE:
                begin
                    if (cur_eq)
                    begin
                        done = 1'b1;
                        vw   = 1'b1;
                        vwd  = 32'd0;
                        ldec = val_nz;
                    end
                    else if (cur_zero || last_step)
                    begin
                        done = 1'b1;
                    end
                end
                REQ_GET:
                begin
                    if (cur_eq)
                    begin
                        done = 1'b1;
                        rv   = val_rd;
                        fd   = 1'b1;
                    end
                    else if (cur_zero || last_step)
                    begin
                        done = 1'b1;
                    end
                end
                REQ_RAW:
                begin
                    done = 1'b1;
                    if (32'(job_reg.slot_index) >= 32'(n))
                    begin
                        st = ST_RANGE;
                    end
                    else if (!cur_zero)
                    begin
                        rv = val_rd;
                        fd = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
        lv = live_reg - CW'(ldec) + CW'(linc);

        case (state_reg)
            B_INIT:
            begin
                key_we = 1'b1;
                wr_key = 32'd0;
                if (last_idx)
                begin
                    pos_next   = '0;
                    state_next = B_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            B_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    job_next  = q_data;
                    step_next = '0;
                    if (q_data.req_type == REQ_CLEAR)
                    begin
                        pos_next   = '0;
                        state_next = B_CLEAR;
                    end
                    else
                    begin
                        if (q_data.req_type == REQ_RAW)
                        begin
                            pos_next = IW'(q_data.slot_index);
                        end
                        else
                        begin
                            pos_next = IW'(q_data.home);
                        end
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (done)
                begin
                    // hold here with no write until the result slot frees up
                    if (out_free)
                    begin
                        key_we     = kw;
                        val_we     = vw;
                        wr_val     = vwd;
                        live_next  = lv;
                        ov_next    = 1'b1;
                        rv_next    = rv;
                        st_next    = st;
                        fd_next    = fd;
                        lc_next    = (32'(lv) > 32'd2047) ? 11'h7ff : 11'(lv);
                        state_next = B_IDLE;
                    end
                end
                else
                begin
                    pos_next   = pos_wrap;
                    step_next  = step_reg + 1'b1;
                    state_next = B_READ;
                end
            end
            B_CLEAR:
            begin
                key_we = 1'b1;
                wr_key = 32'd0;
                if (last_idx)
                begin
                    if (out_free)
                    begin
                        live_next  = '0;
                        ov_next    = 1'b1;
                        rv_next    = 32'd0;
                        st_next    = ST_OK;
                        fd_next    = 1'b0;
                        lc_next    = 11'd0;
                        state_next = B_IDLE;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_INIT;
            pos_reg   <= '0;
            step_reg  <= '0;
            live_reg  <= '0;
            ov_reg    <= 1'b0;
            lc_reg    <= 11'd0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            step_reg  <= step_next;
            live_reg  <= live_next;
            ov_reg    <= ov_next;
            lc_reg    <= lc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        rv_reg  <= rv_next;
        st_reg  <= st_next;
        fd_reg  <= fd_next;
    end

`ifndef NO_ASSERTIONS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) <= 32'(TABLE_SLOTS))
        else $error("live entry count above table size");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CHECK |-> 32'(step_reg) < 32'(n))
        else $error("probe ran past one full round");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHECK && job_reg.req_type != REQ_RAW) |-> 32'(pos_reg) < 32'(n))
        else $error("probe position outside slots in use");

    a_no_pop_init: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_INIT |-> !q_ready)
        else $error("job taken during reset sweep");
`endif

endmodule

// ===== hw/rtl/linear_probe_hash_map_32.sv =====
// Key/value hash map of 32-bit pairs with linear probing on murmur3-mixed keys.
// After reset the key memory is swept to empty, one slot per cycle, and no
// request is taken until that ends. In the intake a request then passes two
// registered multiplies, a fold and a remainder unit at 4 bits per cycle; in
// the probe engine each probed slot takes a read state and a check state, and
// the key and value memories are read once per probe. Set, erase and get probe
// up to n slots, raw one slot, and clear sweeps the whole table.
// Intake and probe engine overlap through a two-entry queue, so the sustained
// rate is set by the slower of the two.
module linear_probe_hash_map_32
    import lphm_pkg::*;
#(
    parameter int TABLE_SLOTS = TableSlotsDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [31:0] key,
    input  logic [31:0] value,
    input  logic [9:0]  slot_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic [1:0]  status,
    output logic        found,
    output logic [10:0] live_count
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    logic [CfgW-1:0] slots_reg;
    logic [CW-1:0]   n;
    logic            init;
    logic            fq_valid;
    logic            fq_ready;
    job_t            fq_data;
    logic            qb_valid;
    logic            qb_ready;
    job_t            qb_data;
    status_t         st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= CfgReset;
        end
        else if (cfg_we)
        begin
            slots_reg <= cfg_wdata;
        end
    end

    // zero acts as one slot, oversize as the full table
    always_comb
    begin
        if (slots_reg == '0)
        begin
            n = CW'(1);
        end
        else if (32'(slots_reg) > 32'(TABLE_SLOTS))
        begin
            n = CW'(TABLE_SLOTS);
        end
        else
        begin
            n = CW'(slots_reg);
        end
    end

    lphm_front #(
        .CW(CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold       (init),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .key        (key),
        .value      (value),
        .slot_index (slot_index),
        .n          (n),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    lphm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    lphm_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IW          (IW),
        .CW          (CW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .n            (n),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_data       (qb_data),
        .init         (init),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (st),
        .found        (found),
        .live_count   (live_count)
    );

    assign status = st;

endmodule

// ===== tb/tb_linear_probe_hash_map_32.sv =====
// testbench of the linear probe hash map: directed and random requests against a predictor
module tb_linear_probe_hash_map_32;
    import lphm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Slots = 1024;
    localparam int IdleLimit = 200000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [31:0] key;
    logic [31:0] value;
    logic [9:0]  slot_index;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result_value;
    logic [1:0]  status;
    logic        found;
    logic [10:0] live_count;

    typedef struct packed {
        logic [31:0] rv;
        logic [1:0]  st;
        logic        fd;
        logic [10:0] lc;
    } reply_t;

    // predictor state
    logic [31:0] map_keys [Slots];
    logic [31:0] map_vals [Slots];
    int unsigned map_live;
    logic [10:0] map_size;

    reply_t      reply_q[$];
    int          errors;
    int          replies_seen;
    int          idle_cycles;
    bit          timed_out;
    bit          rx_stall_on;
    logic [31:0] key_pool[$];

    linear_probe_hash_map_32 dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .key(key),
        .value(value), .slot_index(slot_index), .out_valid(out_valid),
        .out_ready(out_ready), .result_value(result_value), .status(status),
        .found(found), .live_count(live_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] fmix(logic [31:0] k);
        logic [31:0] h;
        h = k ^ (k >> 16);
        h = h * MixC1;
        h = h ^ (h >> 13);
        h = h * MixC2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic int unsigned used_slots();
        if (map_size == 0)
            return 1;
        if (map_size > Slots)
            return Slots;
        return map_size;
    endfunction

    function automatic reply_t predict_reply(logic [2:0] rq, logic [31:0] k,
                                             logic [31:0] v, logic [9:0] si);
        reply_t r;
        int unsigned n;
        int unsigned pos;
        r = '0;
        n = used_slots();
        if (rq <= REQ_GET && k == 0)
            r.st = ST_KEY_ZERO;
        else if (rq == REQ_SET)
        begin
            r.st = ST_FULL;
            pos = fmix(k) % n;
            for (int i = 0; i < n; i++)
            begin
                if (map_keys[pos] == k || map_keys[pos] == 0)
                begin
                    if (map_keys[pos] != 0 && map_vals[pos] != 0)
                        map_live--;
                    map_keys[pos] = k;
                    map_vals[pos] = v;
                    if (v != 0)
                        map_live++;
                    r.st = ST_OK;
                    break;
                end
                pos = (pos + 1) % n;
            end
        end
        else if (rq == REQ_ERASE || rq == REQ_GET)
        begin
            pos = fmix(k) % n;
            for (int i = 0; i < n; i++)
            begin
                if (map_keys[pos] == k)
                begin
                    if (rq == REQ_ERASE)
                    begin
                        if (map_vals[pos] != 0)
                            map_live--;
                        map_vals[pos] = 0;
                    end
                    else
                    begin
                        r.rv = map_vals[pos];
                        r.fd = 1'b1;
                    end
                    break;
                end
                if (map_keys[pos] == 0)
                    break;
                pos = (pos + 1) % n;
            end
        end
        else if (rq == REQ_RAW)
        begin
            if (si >= n)
                r.st = ST_RANGE;
            else if (map_keys[si] != 0)
            begin
                r.rv = map_vals[si];
                r.fd = 1'b1;
            end
        end
        else if (rq == REQ_CLEAR)
        begin
            for (int i = 0; i < Slots; i++)
            begin
                map_keys[i] = 0;
                map_vals[i] = 0;
            end
            map_live = 0;
        end
        r.lc = (map_live > 2047) ? 11'd2047 : map_live[10:0];
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // called at a falling edge; valid drops only when a gap precedes the request
    task automatic send_req(logic [2:0] rq, logic [31:0] k, logic [31:0] v, logic [9:0] si);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req_type   <= rq;
        key        <= k;
        value      <= v;
        slot_index <= si;
        in_valid   <= 1'b1;
        reply_q.push_back(predict_reply(rq, k, v, si));
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (reply_q.size() != 0 && !timed_out)
            @(posedge clk);
        // extra wait after the last reply; a clear replies only when its sweep is done
        repeat (2 * Slots + 100) @(posedge clk);
    endtask

    task automatic write_size(logic [10:0] sz);
        wait_drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= sz;
        map_size = sz;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    task automatic test_directed();
        send_req(REQ_GET, 32'h1, 0, 0);
        send_req(REQ_SET, 32'h0, 32'h5, 0);
        send_req(REQ_ERASE, 32'h0, 0, 0);
        send_req(REQ_GET, 32'h0, 0, 0);
        send_req(REQ_SET, 32'hffffffff, 32'hffffffff, 0);
        send_req(REQ_SET, 32'h1, 32'h1, 0);
        send_req(REQ_SET, 32'h1, 32'h2, 0);
        send_req(REQ_SET, 32'h2, 32'h0, 0);
        send_req(REQ_GET, 32'hffffffff, 0, 10'h3ff);
        send_req(REQ_GET, 32'h1, 0, 0);
        send_req(REQ_ERASE, 32'h1, 0, 0);
        send_req(REQ_GET, 32'h1, 0, 0);
        send_req(REQ_ERASE, 32'h12345678, 0, 0);
        send_req(REQ_RAW, 0, 0, 10'(fmix(32'hffffffff) % Slots));
        send_req(REQ_RAW, 0, 0, 10'h3ff);
        send_req(REQ_RAW, 0, 0, 10'h0);
        for (int u = 5; u < 8; u++)
            send_req(u[2:0], 32'haaaa5555, 32'h5555aaaa, 10'h2aa);
        send_req(REQ_CLEAR, 0, 0, 0);
        send_req(REQ_GET, 32'hffffffff, 0, 0);
    endtask

    // table of the given size; small ones fill up and wrap and get raw indexes out of range
    task automatic test_small_table(logic [10:0] sz, int count);
        write_size(sz);
        send_req(REQ_CLEAR, 0, 0, 0);
        key_pool.delete();
        for (int i = 0; i < count && !timed_out; i++)
        begin
            int p;
            logic [31:0] k;
            p = $urandom_range(0, 99);
            k = pick_key();
            if ($urandom_range(0, 30) == 0)
                k = 0;
            if (key_pool.size() < 40 && k != 0)
                key_pool.push_back(k);
            if (p < 35)
                send_req(REQ_SET, k, ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom(), 0);
            else if (p < 50)
                send_req(REQ_ERASE, k, $urandom(), 10'($urandom()));
            else if (p < 75)
                send_req(REQ_GET, k, $urandom(), 10'($urandom()));
            else if (p < 92)
                send_req(REQ_RAW, $urandom(), $urandom(),
                         10'(($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 7)));
            else if (p < 95)
                send_req(REQ_CLEAR, $urandom(), $urandom(), 10'($urandom()));
            else
                send_req(3'($urandom_range(5, 7)), $urandom(), $urandom(), 10'($urandom()));
        end
    endtask

    task automatic test_unclear_resize();
        write_size(11'd8);
        for (int i = 1; i <= 8; i++)
            send_req(REQ_SET, i * 32'h01010101, i, 0);
        write_size(11'd2);
        send_req(REQ_RAW, 0, 0, 10'd5);
        send_req(REQ_SET, 32'h77, 32'h1, 0);
        send_req(REQ_CLEAR, 0, 0, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        req_type = '0;
        key = '0;
        value = '0;
        slot_index = '0;
        errors = 0;
        map_live = 0;
        map_size = CfgReset;
        for (int i = 0; i < Slots; i++)
        begin
            map_keys[i] = 0;
            map_vals[i] = 0;
        end
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_small_table(11'd0, 60);
        test_small_table(11'd1, 60);
        test_small_table(11'd4, 250);
        test_small_table(11'd13, 250);
        test_small_table(11'd2047, 80);
        test_small_table(11'd1024, 300);
        test_unclear_resize();
        test_small_table(11'd64, 400);
        wait_drain();
        if (!timed_out)
        begin
            $display("covered set/erase/get/raw/clear and unknown codes, %0d replies,", replies_seen);
            $display("table sizes 0,1,2,4,8,13,64,1024,2047 incl. full tables and wrap");
            if (errors == 0 && reply_q.size() == 0)
                $display("[linear_probe_hash_map_32] OK");
            else
                $display("[linear_probe_hash_map_32] ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with stall-free stretches
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            int g;
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                rx_stall_on = !rx_stall_on;
            g = rx_stall_on ? gap_len() : 0;
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            replies_seen++;
            if (reply_q.size() == 0)
            begin
                $error("beat with no pending reply");
                errors++;
            end
            else
            begin
                reply_t e;
                e = reply_q.pop_front();
                if (result_value !== e.rv)
                begin
                    $error("result_value exp %h got %h", e.rv, result_value);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $error("status exp %0d got %0d", e.st, status);
                    errors++;
                end
                if (found !== e.fd)
                begin
                    $error("found exp %0d got %0d", e.fd, found);
                    errors++;
                end
                if (live_count !== e.lc)
                begin
                    $error("live_count exp %0d got %0d", e.lc, live_count);
                    errors++;
                end
            end
        end
    end

    // idle watchdog; also covers the reset sweep and long probe runs
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[linear_probe_hash_map_32] ERROR");
            $finish;
        end
    end

endmodule

// ===== linear_probe_hash_map_32.f =====
hw/rtl/lphm_pkg.sv
hw/rtl/lphm_front.sv
hw/rtl/lphm_queue.sv
hw/rtl/lphm_back.sv
hw/rtl/linear_probe_hash_map_32.sv
tb/tb_linear_probe_hash_map_32.sv
